/* rtl/core/fcar_pkg.sv */
// Shared constants and types for the framed command parser with acknowledged retries.
package fcar_pkg;

    localparam int ADC_BITS_DEF = 12;

    // Framing characters and command letters.
    localparam logic [7:0] CH_START = 8'h21;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;

    localparam logic [2:0] BODY_MAX      = 3'd3;
    localparam logic [2:0] BODY_OVERFLOW = 3'd4;

    localparam int          PERIOD_W     = 16;
    localparam logic [15:0] RETRY_RESET  = 16'd3000;

    localparam int         APB_ADDR_W       = 3;
    localparam int         APB_DATA_W       = 32;
    localparam logic [0:0] REG_RETRY_PERIOD = 1'b0;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Command decoded at the end-of-frame character.
    typedef struct packed {
        logic rst;
        logic ok;
    } cmd_t;

endpackage

/* rtl/core/fcar_cfg.sv */
// APB register bank holding the retry period.
module fcar_cfg
    import fcar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PERIOD_W-1:0]   retry_period
);

    logic [PERIOD_W-1:0] retry_period_reg;
    logic [PERIOD_W-1:0] retry_period_next;
    logic                sel_period;

    assign pready     = 1'b1;
    assign sel_period = (paddr[APB_ADDR_W-1] == REG_RETRY_PERIOD);

    always_comb
    begin
        retry_period_next = retry_period_reg;
        if (psel && penable && pwrite && pready && sel_period)
        begin
            retry_period_next = pwdata[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_period_reg <= RETRY_RESET;
        end
        else
        begin
            retry_period_reg <= retry_period_next;
        end
    end

    assign prdata       = sel_period ? APB_DATA_W'(retry_period_reg) : '0;
    assign retry_period = retry_period_reg;

endmodule

/* rtl/core/fcar_parser.sv */
// Frame parser: collects the body between start and end characters and decodes commands.
module fcar_parser
    import fcar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output cmd_t       cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [2:0] body_len_reg;
    logic [2:0] body_len_next;
    logic [7:0] body_chars_reg [3];
    logic       char_wr;
    logic       is_start;
    logic       is_end;
    logic       body_rst;
    logic       body_ok;

    assign is_start = (rx_byte == CH_START);
    assign is_end   = in_frame_reg && (rx_byte == CH_END);

    assign body_rst = (body_len_reg == 3'd3) && (body_chars_reg[0] == CH_R)
                      && (body_chars_reg[1] == CH_S) && (body_chars_reg[2] == CH_T);
    assign body_ok  = (body_len_reg == 3'd2) && (body_chars_reg[0] == CH_O)
                      && (body_chars_reg[1] == CH_K);

    assign cmd.rst = is_end && body_rst;
    assign cmd.ok  = is_end && body_ok;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        body_len_next = body_len_reg;
        char_wr       = 1'b0;
        if (step)
        begin
            if (is_start)
            begin
                // A start character always opens a fresh, empty body.
                in_frame_next = 1'b1;
                body_len_next = '0;
            end
            else if (is_end)
            begin
                in_frame_next = 1'b0;
            end
            else if (in_frame_reg)
            begin
                if (body_len_reg < BODY_MAX)
                begin
                    char_wr       = 1'b1;
                    body_len_next = body_len_reg + 3'd1;
                end
                else
                begin
                    body_len_next = BODY_OVERFLOW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            body_len_reg <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            body_len_reg <= body_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_wr)
        begin
            body_chars_reg[body_len_reg[1:0]] <= rx_byte;
        end
    end

endmodule

/* rtl/core/fcar_ctrl.sv */
// Acknowledge controller: latches the sample, tracks the wait state and runs the retry timer.
module fcar_ctrl
    import fcar_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                action,
    input  cmd_t                cmd,
    input  logic [ADC_BITS-1:0] adc_sample,
    input  logic [PERIOD_W-1:0] retry_period,
    output logic                res_send,
    output logic [ADC_BITS-1:0] res_value,
    output logic                res_toggle,
    output logic                res_await
);

    logic                wait_reg;
    logic                wait_next;
    logic [ADC_BITS-1:0] held_reg;
    logic [ADC_BITS-1:0] held_next;
    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;

    always_comb
    begin
        wait_next  = wait_reg;
        held_next  = held_reg;
        count_next = count_reg;
        res_send   = 1'b0;
        res_toggle = 1'b0;
        if (action == ACT_BYTE)
        begin
            if (!wait_reg && cmd.rst)
            begin
                held_next  = adc_sample;
                res_send   = 1'b1;
                res_toggle = 1'b1;
                wait_next  = 1'b1;
                count_next = retry_period;
            end
            else if (wait_reg && cmd.ok)
            begin
                wait_next  = 1'b0;
                count_next = '0;
            end
        end
        else if (wait_reg)
        begin
            // A countdown at zero or one expires, so a zero period acts as one tick.
            if (count_reg <= PERIOD_W'(1))
            begin
                res_send   = 1'b1;
                count_next = retry_period;
            end
            else
            begin
                count_next = count_reg - PERIOD_W'(1);
            end
        end
    end

    assign res_value = held_next;
    assign res_await = wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg  <= 1'b0;
            held_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            wait_reg  <= wait_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/framed_command_ack_retransmit_top.sv */
// Top level of the framed command parser with acknowledged, retried value reports.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  tuser: action; tdata: rx_byte, adc_sample
//  m_*       out        m_tvalid/m_tready  tdata: send_frame, frame_value, toggle_led,
//                                          awaiting_ack
//  APB       in         psel/penable       retry_period_ticks at address 0
//
// Each word is held in an input register and processed once the output register is free or
// drained; the parser and controller then update their state and the result is written to the
// output register. One word per cycle is sustained while m_tready stays high.
// The output register lets a new word be taken while a result still waits on m_tready.
// Reset is asynchronous and active low and clears all control state at once.
module framed_command_ack_retransmit_top
    import fcar_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Bits from low: rx_byte[7:0], adc_sample, zero padding.
    input  logic [((8+ADC_BITS+7)/8)*8-1:0]    s_tdata,
    // Bits from low: action.
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Bits from low: send_frame, frame_value, toggle_led, awaiting_ack, zero padding.
    output logic [((ADC_BITS+3+7)/8)*8-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [APB_ADDR_W-1:0]              paddr,
    input  logic [APB_DATA_W-1:0]              pwdata,
    output logic [APB_DATA_W-1:0]              prdata,
    output logic                               pready
);

    localparam int OUT_W = ((ADC_BITS + 3 + 7) / 8) * 8;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic                in_action_reg;
    logic [7:0]          in_byte_reg;
    logic [ADC_BITS-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_send_reg;
    logic [ADC_BITS-1:0] out_value_reg;
    logic                out_toggle_reg;
    logic                out_await_reg;
    logic                advance;
    logic                in_take;
    logic                byte_step;
    logic [PERIOD_W-1:0] retry_period;
    cmd_t                cmd;
    logic                res_send;
    logic [ADC_BITS-1:0] res_value;
    logic                res_toggle;
    logic                res_await;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign byte_step = advance && (in_action_reg == ACT_BYTE);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata[7:0];
            in_sample_reg <= s_tdata[8 +: ADC_BITS];
        end
        if (advance)
        begin
            out_send_reg   <= res_send;
            out_value_reg  <= res_value;
            out_toggle_reg <= res_toggle;
            out_await_reg  <= res_await;
        end
    end

    fcar_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .retry_period (retry_period)
    );

    fcar_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (byte_step),
        .rx_byte (in_byte_reg),
        .cmd     (cmd)
    );

    fcar_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .action       (in_action_reg),
        .cmd          (cmd),
        .adc_sample   (in_sample_reg),
        .retry_period (retry_period),
        .res_send     (res_send),
        .res_value    (res_value),
        .res_toggle   (res_toggle),
        .res_await    (res_await)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_await_reg, out_toggle_reg, out_value_reg, out_send_reg});

    // A toggle only comes with an accepted reset command, which sends and starts waiting.
    a_toggle_implies_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_toggle_reg) |-> (out_send_reg && out_await_reg))
        else $error("toggle without send or wait");

    // A held input word is never dropped while the output side stalls.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost during stall");

    // Processing a word always leaves a result in the output register.
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word produced no result");

    // The input side is only blocked while a word is held.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input blocked while empty");

endmodule
